// File: rtl/iiea_pkg.sv
// Package for the indexed insert/erase array: sizes, request and status codes,
// sequencer states and the payload and RAM request structs. No dependencies.
package iiea_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 7;
  localparam int WORD_W   = 32;
  localparam int CMPW     = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_DROP_LAST  = 3'd1,
    REQ_PREPEND    = 3'd2,
    REQ_DROP_FIRST = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_ERASE      = 3'd5,
    REQ_READ       = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_PUT,
    S_ERA_RD,
    S_ERA_WR,
    S_RD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [WORD_W-1:0] value;
    logic [IDX_W-1:0]         index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } ram_req_t;

  // The count field carries the stored count masked to its width.
  function automatic logic [CNT_W-1:0] count_field(logic [CW-1:0] c);
    logic [CMPW-1:0] w;
    w = CMPW'(c);
    return w[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/indexed_insert_erase_array.sv
// Top level of the indexed insert/erase array: sequencer, entry RAM and
// result output register. Depends on iiea_pkg, iiea_ram and iiea_seq.
//
//   channel | signals                            | moves
//   --------+------------------------------------+-------------------------
//   in      | in_valid_i, in_ready_o, in_data_i  | one request per transfer
//   out     | out_valid_o, out_ready_i, out_data_o | one result per transfer
//
// One request is worked on at a time. Fails, pop back and unused codes need no
// shift, and a read waits for the registered RAM read. An insert or an erase
// shifts the entries from its index to the back; each entry moved is a read and
// a write-back through the single RAM.
// Reset clears the count and the sequencer; the RAM is not cleared and no
// entry is read before it has been written.
// A result that waits in the output register does not stop the next request
// from being accepted; the sequencer only holds when its own result finds
// the output register still occupied.
module indexed_insert_erase_array (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  iiea_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output iiea_pkg::out_item_t  out_data_o
);

  iiea_pkg::ram_req_t          ram_req;
  logic [iiea_pkg::WORD_W-1:0] ram_rdata;
  iiea_pkg::out_item_t         res;
  logic                        res_valid;
  logic                        res_ready;
  logic                        out_valid_q;
  iiea_pkg::out_item_t         out_data_q;

  // The sequencer runs every request and leaves its result here.
  iiea_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // The entry store: one write and one registered read each cycle.
  iiea_ram #(
    .DATA_W (iiea_pkg::WORD_W),
    .DEPTH  (iiea_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // The output register takes a result when it is empty or is being emptied
  // by a transfer in the same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/iiea_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module iiea_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: rtl/iiea_seq.sv
// Request sequencer: checks, entry count and the read/write-back moves that
// shift entries in the RAM. Depends on iiea_pkg.
module iiea_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  iiea_pkg::in_item_t           in_data_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output iiea_pkg::out_item_t          res_o,
  output iiea_pkg::ram_req_t           ram_o,
  input  logic [iiea_pkg::WORD_W-1:0]  ram_rdata_i
);

  iiea_pkg::state_e state_q, state_d;
  logic [iiea_pkg::CW-1:0]     count_q, count_d;
  logic [iiea_pkg::AW-1:0]     pos_q, pos_d;
  logic [iiea_pkg::AW-1:0]     ptr_q, ptr_d;
  logic [iiea_pkg::WORD_W-1:0] word_q, word_d;
  logic [iiea_pkg::WORD_W-1:0] rdval_q, rdval_d;
  iiea_pkg::status_e           status_q, status_d;

  iiea_pkg::req_e              req;
  logic [iiea_pkg::CMPW-1:0]   idx_w, cnt_w;
  logic                        full, empty;
  logic                        do_ins, do_era;
  logic [iiea_pkg::AW-1:0]     new_pos;

  assign req   = iiea_pkg::req_e'(in_data_i.req_type);
  assign idx_w = iiea_pkg::CMPW'(in_data_i.index);
  assign cnt_w = iiea_pkg::CMPW'(count_q);
  assign full  = count_q >= iiea_pkg::CW'(iiea_pkg::CAPACITY);
  assign empty = count_q == '0;

  assign in_ready_o  = state_q == iiea_pkg::S_IDLE;
  assign res_valid_o = state_q == iiea_pkg::S_RESP;
  assign res_o.status     = status_q;
  assign res_o.count      = iiea_pkg::count_field(count_q);
  assign res_o.read_value = rdval_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    ptr_d    = ptr_q;
    word_d   = word_q;
    rdval_d  = rdval_q;
    status_d = status_q;
    do_ins   = 1'b0;
    do_era   = 1'b0;
    new_pos  = iiea_pkg::AW'(idx_w);
    ram_o    = '0;

    case (state_q)
      iiea_pkg::S_IDLE: begin
        if (in_valid_i) begin
          status_d = iiea_pkg::ST_OK;
          rdval_d  = '0;
          word_d   = in_data_i.value;
          state_d  = iiea_pkg::S_RESP;
          case (req)
            iiea_pkg::REQ_APPEND: begin
              if (full) status_d = iiea_pkg::ST_FULL;
              else begin
                new_pos = iiea_pkg::AW'(count_q);
                do_ins  = 1'b1;
              end
            end
            iiea_pkg::REQ_DROP_LAST: begin
              if (empty) status_d = iiea_pkg::ST_EMPTY;
              else count_d = count_q - iiea_pkg::CW'(1);
            end
            iiea_pkg::REQ_PREPEND: begin
              if (full) status_d = iiea_pkg::ST_FULL;
              else begin
                new_pos = '0;
                do_ins  = 1'b1;
              end
            end
            iiea_pkg::REQ_DROP_FIRST: begin
              if (empty) status_d = iiea_pkg::ST_EMPTY;
              else begin
                new_pos = '0;
                do_era  = 1'b1;
              end
            end
            iiea_pkg::REQ_INSERT: begin
              if (full) status_d = iiea_pkg::ST_FULL;
              else if (idx_w > cnt_w) status_d = iiea_pkg::ST_BAD_INDEX;
              else do_ins = 1'b1;
            end
            iiea_pkg::REQ_ERASE: begin
              if (empty) status_d = iiea_pkg::ST_EMPTY;
              else if (idx_w >= cnt_w) status_d = iiea_pkg::ST_BAD_INDEX;
              else do_era = 1'b1;
            end
            iiea_pkg::REQ_READ: begin
              if (empty) status_d = iiea_pkg::ST_EMPTY;
              else if (idx_w >= cnt_w) status_d = iiea_pkg::ST_BAD_INDEX;
              else begin
                // Issue the read now; the word is on the read port next cycle.
                ram_o.re    = 1'b1;
                ram_o.raddr = new_pos;
                state_d     = iiea_pkg::S_RD;
              end
            end
            default: ;
          endcase

          if (do_ins) begin
            pos_d = new_pos;
            if (iiea_pkg::CW'(new_pos) == count_q) begin
              state_d = iiea_pkg::S_PUT;
            end else begin
              ptr_d   = iiea_pkg::AW'(count_q);
              state_d = iiea_pkg::S_INS_RD;
            end
          end
          if (do_era) begin
            pos_d = new_pos;
            ptr_d = new_pos;
            if (iiea_pkg::CW'(new_pos) + iiea_pkg::CW'(1) == count_q) begin
              count_d = count_q - iiea_pkg::CW'(1);
            end else begin
              state_d = iiea_pkg::S_ERA_RD;
            end
          end
        end
      end
      iiea_pkg::S_INS_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ptr_q - iiea_pkg::AW'(1);
        state_d     = iiea_pkg::S_INS_WR;
      end
      iiea_pkg::S_INS_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ptr_q;
        ram_o.wdata = ram_rdata_i;
        ptr_d       = ptr_q - iiea_pkg::AW'(1);
        state_d     = (ptr_d == pos_q) ? iiea_pkg::S_PUT : iiea_pkg::S_INS_RD;
      end
      iiea_pkg::S_PUT: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = pos_q;
        ram_o.wdata = word_q;
        count_d     = count_q + iiea_pkg::CW'(1);
        state_d     = iiea_pkg::S_RESP;
      end
      iiea_pkg::S_ERA_RD: begin
        ram_o.re    = 1'b1;
        ram_o.raddr = ptr_q + iiea_pkg::AW'(1);
        state_d     = iiea_pkg::S_ERA_WR;
      end
      iiea_pkg::S_ERA_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = ptr_q;
        ram_o.wdata = ram_rdata_i;
        ptr_d       = ptr_q + iiea_pkg::AW'(1);
        if (iiea_pkg::CW'(ptr_q) + iiea_pkg::CW'(2) == count_q) begin
          count_d = count_q - iiea_pkg::CW'(1);
          state_d = iiea_pkg::S_RESP;
        end else begin
          state_d = iiea_pkg::S_ERA_RD;
        end
      end
      iiea_pkg::S_RD: begin
        // The word read in the accepting cycle is captured here.
        rdval_d = ram_rdata_i;
        state_d = iiea_pkg::S_RESP;
      end
      iiea_pkg::S_RESP: begin
        if (res_ready_i) state_d = iiea_pkg::S_IDLE;
      end
      default: state_d = iiea_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iiea_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    word_q   <= word_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
  end

  // The stored count never passes the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= iiea_pkg::CW'(iiea_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A shift never reads and writes the same entry in one cycle.
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_o.we && ram_o.re && ram_o.waddr == ram_o.raddr))
    else $error("read and write of one entry in the same cycle");

  // One request moves the count by at most one entry.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |->
      (count_q == $past(count_q) + iiea_pkg::CW'(1) ||
       count_q == $past(count_q) - iiea_pkg::CW'(1)))
    else $error("entry count jumped");

  // A read result is offered right after its word has been captured.
  a_read_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iiea_pkg::S_RD |=> res_valid_o)
    else $error("read result not offered after capture");

endmodule

// File: sim/tb_indexed_insert_erase_array.sv
// Self-checking testbench for indexed_insert_erase_array: directed and random
// list requests, with a shadow list predicting every result.
// Depends on iiea_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_indexed_insert_erase_array;

  // The request code that the block treats as a no-operation.
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1030;
  // The slowest request shifts the whole list.
  localparam int DRAIN_CYCLES = 4 * iiea_pkg::CAPACITY;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int REPORT_MAX   = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  iiea_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  iiea_pkg::out_item_t out_data_o;

  indexed_insert_erase_array u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 12 ns clock period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Requests waiting to be offered, and results the block still owes us.
  iiea_pkg::in_item_t  pending_requests[$];
  iiea_pkg::out_item_t expected_results[$];

  // Shadow copy of the stored list; its size is the entry count.
  logic signed [iiea_pkg::WORD_W-1:0] list_words[$];

  // Count that the stimulus generator expects, used only to shape requests.
  int planned_count = 0;

  int  total_items = 1;
  int  sent = 0;
  int  errors = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Applies one request to the shadow list and returns the result it gives.
  // The full and empty checks come ahead of the index check, and a failed
  // request leaves the list alone.
  function automatic iiea_pkg::out_item_t apply_request(iiea_pkg::in_item_t rq);
    iiea_pkg::out_item_t r;
    int                  n;
    bit                  full;
    bit                  empty;
    n     = list_words.size();
    full  = (n >= iiea_pkg::CAPACITY);
    empty = (n == 0);
    r = '0;
    r.status = iiea_pkg::ST_OK;
    case (rq.req_type)
      iiea_pkg::REQ_APPEND: begin
        if (full) r.status = iiea_pkg::ST_FULL;
        else list_words.insert(n, rq.value);
      end
      iiea_pkg::REQ_DROP_LAST: begin
        if (empty) r.status = iiea_pkg::ST_EMPTY;
        else list_words.delete(n - 1);
      end
      iiea_pkg::REQ_PREPEND: begin
        if (full) r.status = iiea_pkg::ST_FULL;
        else list_words.insert(0, rq.value);
      end
      iiea_pkg::REQ_DROP_FIRST: begin
        if (empty) r.status = iiea_pkg::ST_EMPTY;
        else list_words.delete(0);
      end
      iiea_pkg::REQ_INSERT: begin
        // An index equal to the count appends at the back.
        if (full) r.status = iiea_pkg::ST_FULL;
        else if (rq.index > n) r.status = iiea_pkg::ST_BAD_INDEX;
        else list_words.insert(rq.index, rq.value);
      end
      iiea_pkg::REQ_ERASE: begin
        if (empty) r.status = iiea_pkg::ST_EMPTY;
        else if (rq.index >= n) r.status = iiea_pkg::ST_BAD_INDEX;
        else list_words.delete(rq.index);
      end
      iiea_pkg::REQ_READ: begin
        if (empty) r.status = iiea_pkg::ST_EMPTY;
        else if (rq.index >= n) r.status = iiea_pkg::ST_BAD_INDEX;
        else r.read_value = list_words[rq.index];
      end
      default: begin
      end
    endcase
    r.count = iiea_pkg::CNT_W'(list_words.size());
    return r;
  endfunction

  // Adds a request to the stimulus and tracks the count it should leave.
  task automatic queue_req(logic [2:0] rt, logic signed [iiea_pkg::WORD_W-1:0] v,
                           logic [iiea_pkg::IDX_W-1:0] ix);
    iiea_pkg::in_item_t it;
    it.req_type = rt;
    it.value    = v;
    it.index    = ix;
    pending_requests.insert(pending_requests.size(), it);
    case (rt)
      iiea_pkg::REQ_APPEND, iiea_pkg::REQ_PREPEND: begin
        if (planned_count < iiea_pkg::CAPACITY) planned_count++;
      end
      iiea_pkg::REQ_INSERT: begin
        if (planned_count < iiea_pkg::CAPACITY && ix <= planned_count) planned_count++;
      end
      iiea_pkg::REQ_DROP_LAST, iiea_pkg::REQ_DROP_FIRST: begin
        if (planned_count > 0) planned_count--;
      end
      iiea_pkg::REQ_ERASE: begin
        if (planned_count > 0 && ix < planned_count) planned_count--;
      end
      default: begin
      end
    endcase
  endtask

  // Random word with the extremes showing up now and then.
  function automatic logic signed [iiea_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return {1'b1, {(iiea_pkg::WORD_W-1){1'b0}}};
      1:       return {1'b0, {(iiea_pkg::WORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // The run falls in three thirds by requests offered: first the sender idles
  // rarely and the receiver often, then the other way round, then neither.
  function automatic int idle_phase();
    int p;
    p = (sent * 3) / total_items;
    return (p > 2) ? 2 : p;
  endfunction

  function automatic int idle_pct(bit receiver, int phase);
    if (phase == 2) return 0;
    if ((phase == 0) == receiver) return 73;
    return 13;
  endfunction

  // Sender. A request stays on the bus until a transfer takes it; only then
  // may the next one be offered, or the bus go idle.
  always @(negedge clk_i) begin : drive_requests
    bit idle;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      idle = ($urandom_range(99) < idle_pct(1'b0, idle_phase()));
      if (!idle && pending_requests.size() > 0) begin
        in_data_i  <= pending_requests[0];
        pending_requests.delete(0);
        in_valid_i <= 1'b1;
        sent       <= sent + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver. At the start of the last third it holds off for a long stretch
  // while the sender keeps offering, so the output register stays occupied
  // and the block has to stop taking requests.
  always @(negedge clk_i) begin : drive_ready
    int phase;
    if (rst_ni) begin
      phase = idle_phase();
      if (phase == 2 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct(1'b1, phase));
      end
    end
  end

  // Monitor. Every accepted request is predicted right away; every accepted
  // result is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    iiea_pkg::out_item_t want;
    iiea_pkg::out_item_t got;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.insert(expected_results.size(), apply_request(in_data_i));
      end
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("unexpected result: status %0d count %0d read_value %0d",
                     got.status, got.count, got.read_value);
          end
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.status !== want.status || got.count !== want.count ||
              got.read_value !== want.read_value) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("mismatch: expected status %0d count %0d read_value %0d",
                       want.status, want.count, want.read_value);
              $display("          actual   status %0d count %0d read_value %0d",
                       got.status, got.count, got.read_value);
            end
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                         roll;
    int                         lo;
    bit                         filling;
    logic [2:0]                 rt;
    logic [iiea_pkg::IDX_W-1:0] ix;

    // Directed part, starting from the empty list. Empty requests fail
    // with the empty status even with an out-of-range index.
    queue_req(iiea_pkg::REQ_DROP_LAST, 0, 0);
    queue_req(iiea_pkg::REQ_DROP_FIRST, 0, 0);
    queue_req(iiea_pkg::REQ_ERASE, 0, 5);
    queue_req(iiea_pkg::REQ_READ, 0, 0);
    queue_req(iiea_pkg::REQ_INSERT, 32'h1234_5678, 1);
    queue_req(iiea_pkg::REQ_INSERT, 32'h8000_0000, 0);
    queue_req(iiea_pkg::REQ_APPEND, 32'h7fff_ffff, 0);
    queue_req(iiea_pkg::REQ_PREPEND, -1, 0);
    queue_req(iiea_pkg::REQ_READ, 0, 0);
    queue_req(iiea_pkg::REQ_READ, 0, 2);
    queue_req(iiea_pkg::REQ_READ, 0, 3);
    queue_req(iiea_pkg::REQ_ERASE, 0, 3);
    // Inserting at an index equal to the count appends.
    queue_req(iiea_pkg::REQ_INSERT, 0, 3);
    queue_req(iiea_pkg::REQ_INSERT, 32'h5555_5555, 1);
    queue_req(iiea_pkg::REQ_INSERT, 32'h2468_ace0, 64);
    queue_req(iiea_pkg::REQ_READ, 0, 127);
    queue_req(REQ_UNUSED, 32'haaaa_aaaa, 127);
    queue_req(iiea_pkg::REQ_ERASE, 0, 1);
    queue_req(iiea_pkg::REQ_ERASE, 0, 3);
    queue_req(iiea_pkg::REQ_READ, 0, 1);
    queue_req(iiea_pkg::REQ_DROP_FIRST, 0, 0);
    queue_req(iiea_pkg::REQ_DROP_LAST, 0, 0);
    queue_req(iiea_pkg::REQ_DROP_LAST, 0, 0);
    queue_req(iiea_pkg::REQ_READ, 0, 0);

    // Random part. The generator swings between filling the list up to
    // full and draining it to empty, lingering a little at each end so that
    // full and empty failures show up, with valid indexes most of the time.
    filling = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (filling && planned_count == iiea_pkg::CAPACITY && $urandom_range(3) == 0) begin
        filling = 1'b0;
      end else if (!filling && planned_count == 0 && $urandom_range(3) == 0) begin
        filling = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 6) begin
        // Noise: any code, any index from 0 to the capacity.
        rt = 3'($urandom_range(7));
        ix = iiea_pkg::IDX_W'($urandom_range(iiea_pkg::CAPACITY));
      end else if (roll >= 88) begin
        // Index out of range for the current count.
        case ($urandom_range(2))
          0: begin
            rt = iiea_pkg::REQ_INSERT;
            lo = planned_count + 1;
          end
          1: begin
            rt = iiea_pkg::REQ_ERASE;
            lo = planned_count;
          end
          default: begin
            rt = iiea_pkg::REQ_READ;
            lo = planned_count;
          end
        endcase
        ix = (lo > iiea_pkg::CAPACITY) ? iiea_pkg::IDX_W'(iiea_pkg::CAPACITY) :
             iiea_pkg::IDX_W'($urandom_range(iiea_pkg::CAPACITY, lo));
      end else if (roll < 25) begin
        rt = iiea_pkg::REQ_READ;
        ix = (planned_count == 0) ? '0 :
             iiea_pkg::IDX_W'($urandom_range(planned_count - 1));
      end else if ((roll < 73) == filling) begin
        case ($urandom_range(2))
          0:       rt = iiea_pkg::REQ_APPEND;
          1:       rt = iiea_pkg::REQ_PREPEND;
          default: rt = iiea_pkg::REQ_INSERT;
        endcase
        ix = iiea_pkg::IDX_W'($urandom_range(planned_count));
      end else begin
        case ($urandom_range(2))
          0:       rt = iiea_pkg::REQ_DROP_LAST;
          1:       rt = iiea_pkg::REQ_DROP_FIRST;
          default: rt = iiea_pkg::REQ_ERASE;
        endcase
        ix = (planned_count == 0) ? '0 :
             iiea_pkg::IDX_W'($urandom_range(planned_count - 1));
      end
      queue_req(rt, pick_word(), ix);
    end
    total_items = pending_requests.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for the last transfer in, then for every owed result.
    while (pending_requests.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: indexed_insert_erase_array.f
rtl/iiea_pkg.sv
rtl/iiea_ram.sv
rtl/iiea_seq.sv
rtl/indexed_insert_erase_array.sv
sim/tb_indexed_insert_erase_array.sv
